// File: hdl/mqrb_pkg.sv
// mqrb_pkg: shared constants for the multi-queue ring buffer
// operation codes, field widths and default sizes; no dependencies
package mqrb_pkg;

    // default bank size
    localparam int QUEUES_DEF = 4;
    localparam int DEPTH_DEF  = 16;

    // word field widths
    localparam int MODE_W   = 3;
    localparam int QIDX_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int LENGTH_W = 8;
    localparam int FILL_W   = 5;
    localparam int POS_W    = 4;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_OPEN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ENQ    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FORCE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEQ    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd4;

endpackage

// File: hdl/multi_queue_ring_buffer.sv
// multi_queue_ring_buffer: bank of circular fifos with open, enqueue, force
// enqueue, dequeue and peek; depends on mqrb_pkg
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | i_valid / o_stall       | i_mode i_queue_index i_value i_length
//  out     | o_valid / i_stall       | o_ok o_bad_index o_data o_fill o_head_pos
//          |                         | o_tail_pos o_vacant o_is_full
//
// one word per cycle sustained while the result is not stalled; a word is held
// in the input register, where the queue state is read, updated and the entry
// store accessed, then sits in the result register. o_valid rises once the word
// has passed from the input register into the result register.
// i_rst_n (synchronous) clears pointers, counts and lengths; the entry store is
// not cleared. o_stall rises only while a word waits behind a stalled result.
module multi_queue_ring_buffer #(
    parameter int QUEUES = mqrb_pkg::QUEUES_DEF,
    parameter int DEPTH  = mqrb_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [mqrb_pkg::MODE_W-1:0]        i_mode,
    input  logic [mqrb_pkg::QIDX_W-1:0]        i_queue_index,
    input  logic [mqrb_pkg::VALUE_W-1:0]       i_value,
    input  logic [mqrb_pkg::LENGTH_W-1:0]      i_length,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_ok,
    output logic                               o_bad_index,
    output logic [mqrb_pkg::VALUE_W-1:0]       o_data,
    output logic [mqrb_pkg::FILL_W-1:0]        o_fill,
    output logic [mqrb_pkg::POS_W-1:0]         o_head_pos,
    output logic [mqrb_pkg::POS_W-1:0]         o_tail_pos,
    output logic                               o_vacant,
    output logic                               o_is_full
);

    localparam int QW   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int LW   = CW + 1;
    localparam int REQW = mqrb_pkg::LENGTH_W + 1;
    localparam int IXW  = mqrb_pkg::QIDX_W + 1;

    // next position with wrap at the queue length
    function automatic logic [PW-1:0] f_advance(input logic [PW-1:0] pos,
                                                input logic [CW-1:0] len);
        logic [LW-1:0] nxt;
        nxt = LW'(pos) + LW'(1);
        if (len == '0 || nxt >= {1'b0, len})
            return '0;
        return nxt[PW-1:0];
    endfunction

    // input register
    logic                              r_a_valid;
    logic [mqrb_pkg::MODE_W-1:0]       r_mode;
    logic [mqrb_pkg::QIDX_W-1:0]       r_qidx;
    logic [mqrb_pkg::VALUE_W-1:0]      r_value;
    logic [mqrb_pkg::LENGTH_W-1:0]     r_length;

    // per-queue state
    logic [PW-1:0] r_read_ptr  [QUEUES];
    logic [PW-1:0] r_write_ptr [QUEUES];
    logic [CW-1:0] r_count     [QUEUES];
    logic [CW-1:0] r_qlen      [QUEUES];

    // entry store
    logic [mqrb_pkg::VALUE_W-1:0] r_mem [QUEUES][DEPTH];

    // result register
    logic                              r_o_valid;
    logic                              r_ok;
    logic                              r_bad;
    logic                              r_data_sel;
    logic [mqrb_pkg::VALUE_W-1:0]      r_rd_data;
    logic [mqrb_pkg::FILL_W-1:0]       r_fill;
    logic [mqrb_pkg::POS_W-1:0]        r_head;
    logic [mqrb_pkg::POS_W-1:0]        r_tail;
    logic                              r_empty;
    logic                              r_full;

    logic          b_ready;
    logic          a_fire;
    logic          in_take;
    logic          bad;
    logic [QW-1:0] qsel;
    logic [PW-1:0] cur_rd;
    logic [PW-1:0] cur_wr;
    logic [CW-1:0] cur_cnt;
    logic [CW-1:0] cur_len;
    logic          cur_full;
    logic [PW-1:0] n_rd;
    logic [PW-1:0] n_wr;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] n_len;
    logic          n_ok;
    logic          wr_en;
    logic          rd_en;

    // handshake
    assign b_ready = !r_o_valid || !i_stall;
    assign a_fire  = r_a_valid && b_ready;
    assign o_stall = r_a_valid && !b_ready;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode   <= i_mode;
            r_qidx   <= i_queue_index;
            r_value  <= i_value;
            r_length <= i_length;
        end
    end

    // queue select and current state
    assign bad      = ({1'b0, r_qidx} >= IXW'(QUEUES));
    assign qsel     = bad ? '0 : r_qidx[QW-1:0];
    assign cur_rd   = r_read_ptr[qsel];
    assign cur_wr   = r_write_ptr[qsel];
    assign cur_cnt  = r_count[qsel];
    assign cur_len  = r_qlen[qsel];
    assign cur_full = (cur_cnt == cur_len);

    // operation decode
    always_comb begin
        n_rd  = cur_rd;
        n_wr  = cur_wr;
        n_cnt = cur_cnt;
        n_len = cur_len;
        n_ok  = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        unique case (r_mode)
            mqrb_pkg::MODE_OPEN: begin
                n_rd  = '0;
                n_wr  = '0;
                n_cnt = '0;
                n_len = ({1'b0, r_length} > REQW'(DEPTH)) ? CW'(DEPTH) : CW'(r_length);
                n_ok  = 1'b1;
            end
            mqrb_pkg::MODE_ENQ: begin
                if (!cur_full) begin
                    wr_en = 1'b1;
                    n_wr  = f_advance(cur_wr, cur_len);
                    n_cnt = cur_cnt + CW'(1);
                    n_ok  = 1'b1;
                end
            end
            mqrb_pkg::MODE_FORCE: begin
                if (!cur_full) begin
                    wr_en = 1'b1;
                    n_wr  = f_advance(cur_wr, cur_len);
                    n_cnt = cur_cnt + CW'(1);
                    n_ok  = 1'b1;
                end else if (cur_len != '0) begin
                    // overwrite the oldest word
                    wr_en = 1'b1;
                    n_wr  = f_advance(cur_wr, cur_len);
                    n_rd  = f_advance(cur_rd, cur_len);
                    n_ok  = 1'b1;
                end
            end
            mqrb_pkg::MODE_DEQ: begin
                if (cur_cnt != '0) begin
                    rd_en = 1'b1;
                    n_rd  = f_advance(cur_rd, cur_len);
                    n_cnt = cur_cnt - CW'(1);
                    n_ok  = 1'b1;
                end
            end
            mqrb_pkg::MODE_PEEK: begin
                if (cur_cnt != '0) begin
                    rd_en = 1'b1;
                    n_ok  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // per-queue state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) begin
                r_read_ptr[i]  <= '0;
                r_write_ptr[i] <= '0;
                r_count[i]     <= '0;
                r_qlen[i]      <= '0;
            end
        end else if (a_fire && !bad) begin
            r_read_ptr[qsel]  <= n_rd;
            r_write_ptr[qsel] <= n_wr;
            r_count[qsel]     <= n_cnt;
            r_qlen[qsel]      <= n_len;
        end
    end

    // entry store write and registered read
    always_ff @(posedge i_clk) begin
        if (a_fire && !bad && wr_en) begin
            r_mem[qsel][cur_wr] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_rd_data <= r_mem[qsel][cur_rd];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_fire) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_bad      <= bad;
            r_ok       <= !bad && n_ok;
            r_data_sel <= !bad && rd_en;
            r_fill     <= bad ? '0 : mqrb_pkg::FILL_W'(n_cnt);
            r_head     <= bad ? '0 : mqrb_pkg::POS_W'(n_rd);
            r_tail     <= bad ? '0 : mqrb_pkg::POS_W'(n_wr);
            r_empty    <= !bad && (n_cnt == '0);
            r_full     <= !bad && (n_cnt == n_len);
        end
    end

    // outputs
    assign o_valid     = r_o_valid;
    assign o_ok        = r_ok;
    assign o_bad_index = r_bad;
    assign o_data      = r_data_sel ? r_rd_data : '0;
    assign o_fill      = r_fill;
    assign o_head_pos  = r_head;
    assign o_tail_pos  = r_tail;
    assign o_vacant    = r_empty;
    assign o_is_full   = r_full;

endmodule
